// ===== rtl/core/rlp_header_and_integer_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// RLP header and integer encoder - assertion macros
// Concurrent checks clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RLP_HEADER_AND_INTEGER_ENCODER_MACROS_SVH
`define RLP_HEADER_AND_INTEGER_ENCODER_MACROS_SVH

// Same-cycle implication.
`define RLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("rlp encoder check failed");

// Next-cycle implication.
`define RLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("rlp encoder check failed");

`endif

// ===== rtl/core/rlp_enc_pkg.sv =====
// ----------------------------------------------------------------------------
// RLP encoder package
// Field widths, mode codes, prefix bases and the job handed to the serializer.
// ----------------------------------------------------------------------------
package rlp_enc_pkg;

    localparam int C_AMT_W   = 64;
    localparam int C_BYTES   = C_AMT_W / 8;
    localparam int C_CNT_W   = 4;

    localparam logic [1:0] C_MODE_INT    = 2'd0;
    localparam logic [1:0] C_MODE_STR    = 2'd1;
    localparam logic [1:0] C_MODE_LIST   = 2'd2;
    localparam logic [1:0] C_MODE_UNUSED = 2'd3;

    localparam logic [7:0] C_INT_ZERO   = 8'h80;
    localparam logic [7:0] C_INT_LONG   = 8'h80;
    localparam logic [7:0] C_STR_SHORT  = 8'h80;
    localparam logic [7:0] C_STR_LONG   = 8'hb7;
    localparam logic [7:0] C_LIST_SHORT = 8'hc0;
    localparam logic [7:0] C_LIST_LONG  = 8'hf7;
    localparam logic [7:0] C_SINGLE_MAX = 8'h7f;
    localparam logic [5:0] C_SHORT_MAX  = 6'd55;

    // One encoded run: a prefix byte followed by cnt bytes taken from the top of val
    typedef struct packed {
        logic [7:0]         prefix;
        logic [C_CNT_W-1:0] cnt;
        logic [C_AMT_W-1:0] val;
    } t_job;

endpackage

// ===== rtl/core/rlp_header_and_integer_encoder.sv =====
// ----------------------------------------------------------------------------
// RLP header and integer encoder
// Emits the RLP encoding of a 64-bit integer, or the string or list header
// for a payload length, one byte per output item with tlast on the final byte.
// ----------------------------------------------------------------------------
//  Channel  | Dir | tdata (low bit up)                | Other
//  ---------+-----+-----------------------------------+--------------------
//  s_axis   | in  | amount[63:0], first_byte[71:64]   | tuser: mode[1:0]
//  m_axis   | out | out_byte[7:0]                     | tlast
//
// Three register stages (input, byte flags, prefix and alignment) feed a
// serializer with one output byte register. An item gives 0 to 9 bytes. The
// first byte passes the input, flag and job registers, then the output byte
// register; items with no bytes never reach the serializer. Reset clears the
// valid bits and byte count only; back-pressure holds every stage without loss.
module rlp_header_and_integer_encoder
    import rlp_enc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // amount[63:0], first_byte[71:64]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic        m_axis_tlast
);

    `include "rlp_header_and_integer_encoder_macros.svh"

    // stage 1: input register
    logic               r_s1_vld;
    logic [1:0]         r_s1_mode;
    logic [C_AMT_W-1:0] r_s1_amt;
    logic [7:0]         r_s1_first;
    // stage 2: byte flags
    logic               r_s2_vld;
    logic [1:0]         r_s2_mode;
    logic [C_AMT_W-1:0] r_s2_amt;
    logic [C_BYTES-1:0] r_s2_nz;
    logic               r_s2_le7f;
    logic               r_s2_le55;
    logic               r_s2_drop;
    // stage 3: job
    logic               r_s3_vld;
    t_job               r_s3_job;

    logic               w_s1_rdy, w_s2_rdy, w_s3_rdy, w_job_rdy;
    logic [C_BYTES-1:0] w_nz;
    logic               w_drop;
    logic [C_CNT_W-1:0] w_n;
    logic [6:0]         w_shift;
    t_job               w_job;

    assign w_s3_rdy      = !r_s3_vld || w_job_rdy;
    assign w_s2_rdy      = !r_s2_vld || w_s3_rdy;
    assign w_s1_rdy      = !r_s1_vld || w_s2_rdy;
    assign s_axis_tready = w_s1_rdy;

    always_comb begin
        for (int b = 0; b < C_BYTES; b++) begin
            w_nz[b] = |r_s1_amt[8*b +: 8];
        end
    end

    // a one-byte string below 0x80 encodes itself; mode 3 gives nothing
    assign w_drop = (r_s1_mode == C_MODE_UNUSED) ||
                    ((r_s1_mode == C_MODE_STR) && (r_s1_amt == C_AMT_W'(1)) &&
                     !r_s1_first[7]);

    always_comb begin
        w_n = '0;
        for (int b = 0; b < C_BYTES; b++) begin
            if (r_s2_nz[b]) begin
                w_n = C_CNT_W'(b + 1);
            end
        end
    end

    assign w_shift = {4'(C_CNT_W'(C_BYTES) - w_n), 3'b000};

    always_comb begin
        w_job.cnt    = w_n;
        w_job.val    = r_s2_amt << w_shift;
        w_job.prefix = C_INT_ZERO;
        case (r_s2_mode)
            C_MODE_INT: begin
                if (r_s2_nz == '0) begin
                    w_job.prefix = C_INT_ZERO;
                    w_job.cnt    = '0;
                end else if (r_s2_le7f) begin
                    w_job.prefix = r_s2_amt[7:0];
                    w_job.cnt    = '0;
                end else begin
                    w_job.prefix = C_INT_LONG + {4'b0000, w_n};
                end
            end
            C_MODE_STR: begin
                if (r_s2_le55) begin
                    w_job.prefix = C_STR_SHORT + r_s2_amt[7:0];
                    w_job.cnt    = '0;
                end else begin
                    w_job.prefix = C_STR_LONG + {4'b0000, w_n};
                end
            end
            C_MODE_LIST: begin
                if (r_s2_le55) begin
                    w_job.prefix = C_LIST_SHORT + r_s2_amt[7:0];
                    w_job.cnt    = '0;
                end else begin
                    w_job.prefix = C_LIST_LONG + {4'b0000, w_n};
                end
            end
            default: begin
                w_job.cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (w_s1_rdy) begin
                r_s1_vld <= s_axis_tvalid;
            end
            if (w_s2_rdy) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_s3_rdy) begin
                r_s3_vld <= r_s2_vld && !r_s2_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_rdy) begin
            r_s1_mode  <= s_axis_tuser;
            r_s1_amt   <= s_axis_tdata[63:0];
            r_s1_first <= s_axis_tdata[71:64];
        end
        if (w_s2_rdy) begin
            r_s2_mode <= r_s1_mode;
            r_s2_amt  <= r_s1_amt;
            r_s2_nz   <= w_nz;
            r_s2_le7f <= (r_s1_amt[C_AMT_W-1:7] == '0);
            r_s2_le55 <= (r_s1_amt[C_AMT_W-1:6] == '0) && (r_s1_amt[5:0] <= C_SHORT_MAX);
            r_s2_drop <= w_drop;
        end
        if (w_s3_rdy) begin
            r_s3_job <= w_job;
        end
    end

    rlp_enc_ser u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (r_s3_vld),
        .i_job     (r_s3_job),
        .o_job_rdy (w_job_rdy),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast)
    );

    // tail bytes of a run follow without gaps
    `RLP_ASSERT_NEXT(a_run_no_gap, m_axis_tvalid && !m_axis_tlast && m_axis_tready, m_axis_tvalid)
    // a waiting job is not lost
    `RLP_ASSERT_NEXT(a_job_held, r_s3_vld && !w_job_rdy, r_s3_vld)
    // items without bytes never reach the serializer
    `RLP_ASSERT_NEXT(a_drop_empty, r_s2_vld && r_s2_drop && w_s3_rdy, !r_s3_vld)
    // a run carries at most eight tail bytes
    `RLP_ASSERT_NOW(a_short_cnt, r_s3_vld && (r_s3_job.cnt > C_CNT_W'(C_BYTES)), 1'b0)

endmodule

// ===== rtl/core/rlp_enc_ser.sv =====
// ----------------------------------------------------------------------------
// RLP encoder serializer
// Turns a job into bytes on a registered output, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module rlp_enc_ser
    import rlp_enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_vld,
    input  t_job       i_job,
    output logic       o_job_rdy,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast
);

    logic               r_out_vld, n_out_vld;
    logic [7:0]         r_out_byte, n_out_byte;
    logic               r_out_last, n_out_last;
    logic [C_CNT_W-1:0] r_rem, n_rem;
    logic [C_AMT_W-1:0] r_sh, n_sh;
    logic               w_out_free;

    assign w_out_free = !r_out_vld || i_tready;
    assign o_job_rdy  = w_out_free && (r_rem == '0);

    always_comb begin
        n_out_vld  = r_out_vld;
        n_out_byte = r_out_byte;
        n_out_last = r_out_last;
        n_rem      = r_rem;
        n_sh       = r_sh;
        if (w_out_free) begin
            if (r_rem != '0) begin
                // advance through the tail bytes, most significant first
                n_out_vld  = 1'b1;
                n_out_byte = r_sh[C_AMT_W-1 -: 8];
                n_out_last = (r_rem == C_CNT_W'(1));
                n_sh       = {r_sh[C_AMT_W-9:0], 8'h00};
                n_rem      = r_rem - C_CNT_W'(1);
            end else if (i_job_vld) begin
                n_out_vld  = 1'b1;
                n_out_byte = i_job.prefix;
                n_out_last = (i_job.cnt == '0);
                n_sh       = i_job.val;
                n_rem      = i_job.cnt;
            end else begin
                n_out_vld  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_rem     <= '0;
        end else begin
            r_out_vld <= n_out_vld;
            r_rem     <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_sh       <= n_sh;
    end

    assign o_tvalid = r_out_vld;
    assign o_tdata  = r_out_byte;
    assign o_tlast  = r_out_last;

endmodule

// ===== tb/tb_rlp_header_and_integer_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLP header and integer encoder - testbench
// Walks a table of directed items (value and length edges, every mode, the
// self-encoding single byte and the unused mode), then a run of random items.
// Every output byte and its tlast are checked in order against the row's
// bytes or a local encoder model, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_rlp_header_and_integer_encoder;
    import rlp_enc_pkg::*;

    localparam int         RANDOM_ITEMS = 260;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_enc_byte;

    typedef struct {
        logic [1:0]      mode;
        logic [63:0]     amount;
        logic [7:0]      first;
        bit              typed;     // expected bytes given in the row
        int              n_bytes;
        logic [0:8][7:0] bytes;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // amount[63:0], first_byte[71:64]
    logic [1:0]  s_axis_tuser = '0;   // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // out_byte[7:0]
    logic        m_axis_tlast;

    t_enc_byte   enc_bytes_q[$];
    t_stim_row   stim_rows[$];
    int          mismatches = 0;
    int          bytes_checked = 0;
    int          cycle_count = 0;
    int          mode_count[4] = '{0, 0, 0, 0};
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          snk_stall_left = 0;

    rlp_header_and_integer_encoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Prefix base + significant byte count, then those bytes, high first
    function automatic void push_long_form(input logic [7:0] base, input logic [63:0] v);
        int         n;
        logic [63:0] t;
        n = 0;
        t = v;
        while (t != 0) begin
            n++;
            t = t >> 8;
        end
        enc_bytes_q.push_back('{data: base + 8'(n), last: (n == 0)});
        for (int i = n - 1; i >= 0; i--) begin
            enc_bytes_q.push_back('{data: v[8*i +: 8], last: (i == 0)});
        end
    endfunction

    function automatic void push_header(input logic [7:0] short_base,
                                        input logic [7:0] long_base,
                                        input logic [63:0] len);
        if (len <= 64'(C_SHORT_MAX))
            enc_bytes_q.push_back('{data: short_base + len[7:0], last: 1'b1});
        else
            push_long_form(long_base, len);
    endfunction

    function automatic void predict_rlp_bytes(input logic [1:0] mode,
                                              input logic [63:0] amount,
                                              input logic [7:0] first);
        case (mode)
            C_MODE_INT: begin
                if (amount == 0)
                    enc_bytes_q.push_back('{data: C_INT_ZERO, last: 1'b1});
                else if (amount <= 64'(C_SINGLE_MAX))
                    enc_bytes_q.push_back('{data: amount[7:0], last: 1'b1});
                else
                    push_long_form(C_INT_LONG, amount);
            end
            C_MODE_STR: begin
                // a lone byte below 0x80 is its own encoding: no header
                if (!(amount == 1 && first <= C_SINGLE_MAX))
                    push_header(C_STR_SHORT, C_STR_LONG, amount);
            end
            C_MODE_LIST: push_header(C_LIST_SHORT, C_LIST_LONG, amount);
            default: ;
        endcase
    endfunction

    function automatic t_stim_row mk_row(input logic [1:0] mode, input logic [63:0] amount,
                                         input logic [7:0] first, input bit typed,
                                         input int n_bytes, input logic [0:8][7:0] bytes);
        t_stim_row r;
        r.mode    = mode;
        r.amount  = amount;
        r.first   = first;
        r.typed   = typed;
        r.n_bytes = n_bytes;
        r.bytes   = bytes;
        return r;
    endfunction

    function automatic logic [63:0] rand_amount();
        int          r;
        int          len;
        logic [63:0] v;
        r = $urandom_range(9);
        if (r < 6) begin
            len = $urandom_range(1, 64);
            v = {$urandom(), $urandom()};
            return v >> (64 - len);
        end
        if (r == 6) return 64'($urandom_range(0, 60));
        if (r == 7) return 64'($urandom_range(50, 60));
        if (r == 8) return (64'd1 << (8 * $urandom_range(1, 7))) - 64'($urandom_range(0, 1));
        return ~64'd0 - 64'($urandom_range(0, 2));
    endfunction

    // Present one item after a random idle gap, if any, and hold it until accepted
    task automatic send_item(input logic [1:0] mode, input logic [63:0] amount,
                             input logic [7:0] first);
        int gap;
        gap = ($urandom_range(99) < src_idle_pct) ? gap_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {first, amount};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        mode_count[mode]++;
    endtask

    // Output side: random stalls, then check each accepted byte
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (enc_bytes_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected byte %02h last %0b", m_axis_tdata, m_axis_tlast);
            end else begin
                t_enc_byte e;
                e = enc_bytes_q.pop_front();
                bytes_checked++;
                if (e.data !== m_axis_tdata || e.last !== m_axis_tlast) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                                 bytes_checked, e.data, e.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
        if (snk_stall_left > 0) begin
            snk_stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(99) < snk_stall_pct) begin
            snk_stall_left = gap_len() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, enc_bytes_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int          produced;
        logic [1:0]  mode;
        logic [63:0] amount;
        logic [7:0]  first;
        int          r;

        // edges of value and length, every mode, the skipped cases
        stim_rows.push_back(mk_row(C_MODE_INT, 64'd0, 8'h00, 1'b1, 1, {8'h80, 64'd0}));
        stim_rows.push_back(mk_row(C_MODE_INT, 64'd1, 8'hff, 1'b1, 1, {8'h01, 64'd0}));
        stim_rows.push_back(mk_row(C_MODE_INT, 64'h7f, 8'h00, 1'b1, 1, {8'h7f, 64'd0}));
        stim_rows.push_back(mk_row(C_MODE_INT, 64'h80, 8'h00, 1'b1, 2,
                                   {8'h81, 8'h80, 56'd0}));
        stim_rows.push_back(mk_row(C_MODE_INT, 64'hff, 8'h00, 1'b1, 2,
                                   {8'h81, 8'hff, 56'd0}));
        stim_rows.push_back(mk_row(C_MODE_INT, 64'h100, 8'h00, 1'b0, 0, '0));
        stim_rows.push_back(mk_row(C_MODE_INT, ~64'd0, 8'h00, 1'b1, 9,
                                   {8'h88, {8{8'hff}}}));
        stim_rows.push_back(mk_row(C_MODE_INT, 64'd1 << 56, 8'h00, 1'b0, 0, '0));
        stim_rows.push_back(mk_row(C_MODE_INT, 64'h5555_aaaa_0f0f_f0f0, 8'h00, 1'b0, 0, '0));
        stim_rows.push_back(mk_row(C_MODE_STR, 64'd0, 8'h00, 1'b1, 1, {8'h80, 64'd0}));
        stim_rows.push_back(mk_row(C_MODE_STR, 64'd1, 8'h00, 1'b1, 0, '0));
        stim_rows.push_back(mk_row(C_MODE_STR, 64'd1, 8'h7f, 1'b1, 0, '0));
        stim_rows.push_back(mk_row(C_MODE_STR, 64'd1, 8'h80, 1'b1, 1, {8'h81, 64'd0}));
        stim_rows.push_back(mk_row(C_MODE_STR, 64'd1, 8'hff, 1'b1, 1, {8'h81, 64'd0}));
        stim_rows.push_back(mk_row(C_MODE_STR, 64'd55, 8'h00, 1'b1, 1, {8'hb7, 64'd0}));
        stim_rows.push_back(mk_row(C_MODE_STR, 64'd56, 8'h00, 1'b1, 2,
                                   {8'hb8, 8'h38, 56'd0}));
        stim_rows.push_back(mk_row(C_MODE_STR, 64'h1234, 8'h00, 1'b0, 0, '0));
        stim_rows.push_back(mk_row(C_MODE_STR, ~64'd0, 8'h00, 1'b1, 9,
                                   {8'hbf, {8{8'hff}}}));
        stim_rows.push_back(mk_row(C_MODE_LIST, 64'd0, 8'h00, 1'b1, 1, {8'hc0, 64'd0}));
        stim_rows.push_back(mk_row(C_MODE_LIST, 64'd1, 8'h00, 1'b1, 1, {8'hc1, 64'd0}));
        stim_rows.push_back(mk_row(C_MODE_LIST, 64'd55, 8'h00, 1'b1, 1, {8'hf7, 64'd0}));
        stim_rows.push_back(mk_row(C_MODE_LIST, 64'd56, 8'h00, 1'b1, 2,
                                   {8'hf8, 8'h38, 56'd0}));
        stim_rows.push_back(mk_row(C_MODE_LIST, ~64'd0, 8'hff, 1'b1, 9,
                                   {8'hff, {8{8'hff}}}));
        stim_rows.push_back(mk_row(C_MODE_UNUSED, 64'd0, 8'h00, 1'b1, 0, '0));
        stim_rows.push_back(mk_row(C_MODE_UNUSED, ~64'd0, 8'hff, 1'b1, 0, '0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 20;
        snk_stall_pct = 20;
        foreach (stim_rows[i]) begin
            send_item(stim_rows[i].mode, stim_rows[i].amount, stim_rows[i].first);
            if (stim_rows[i].typed) begin
                for (int k = 0; k < stim_rows[i].n_bytes; k++)
                    enc_bytes_q.push_back('{data: stim_rows[i].bytes[k],
                                            last: (k == stim_rows[i].n_bytes - 1)});
            end else begin
                predict_rlp_bytes(stim_rows[i].mode, stim_rows[i].amount, stim_rows[i].first);
            end
        end

        // count only items that give bytes; change idling every 60 of them
        produced = 0;
        while (produced < RANDOM_ITEMS) begin
            case ((produced / 60) % 3)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 15; snk_stall_pct = 15; end
                default: begin src_idle_pct = 50; snk_stall_pct = 50; end
            endcase
            r = $urandom_range(99);
            if (r < 45)      mode = C_MODE_INT;
            else if (r < 70) mode = C_MODE_STR;
            else if (r < 95) mode = C_MODE_LIST;
            else             mode = C_MODE_UNUSED;
            amount = ($urandom_range(99) < 15) ? 64'd1 : rand_amount();
            first  = 8'($urandom_range(255));
            send_item(mode, amount, first);
            predict_rlp_bytes(mode, amount, first);
            if (mode != C_MODE_UNUSED && !(mode == C_MODE_STR && amount == 1 && first < 8'h80))
                produced++;
        end

        s_axis_tvalid <= 1'b0;
        while (enc_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("items: %0d integer, %0d string header, %0d list header, %0d unused mode",
                 mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
        $display("%0d output bytes checked, %0d mismatches", bytes_checked, mismatches);
        if (mismatches == 0 && enc_bytes_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
